[hdl/bobs_pkg.sv]
// Shared types, codes and helpers for the ballistic/orbital body step block.
package bobs_pkg;

  // Default number of fraction bits of the Q format
  localparam int FRAC_BITS_DEF = 16;

  // Datapath width of the shared arithmetic unit
  localparam int ALU_W = 128;

  // Iteration counts of the shared unit
  localparam int DIV_STEPS  = ALU_W;
  localparam int SQRT_STEPS = 34;
  // Top bit of the radicand (radicands stay below 2^68)
  localparam int SQRT_IN_MSB = 2 * SQRT_STEPS - 1;

  // 32-bit signed range in a 48-bit frame
  localparam logic signed [47:0] S32_MAX = 48'sd2147483647;
  localparam logic signed [47:0] S32_MIN = -48'sd2147483648;

  // Operations of the shared unit
  typedef enum logic [1:0] {
    ALU_MUL  = 2'd0,
    ALU_DIV  = 2'd1,
    ALU_SQRT = 2'd2
  } alu_op_t;

  // Request from the sequencer to the shared unit
  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  // Status from the shared unit
  typedef struct packed {
    logic done;
  } alu_rsp_t;

  // Item actions
  typedef enum logic [1:0] {
    ACT_BALLISTIC = 2'd0,
    ACT_ORBITAL   = 2'd1,
    ACT_LOAD      = 2'd2,
    ACT_NONE      = 2'd3
  } action_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_DRAG_COEFF  = 3'd0,
    REG_GRAVITY     = 3'd1,
    REG_BODY_MASS   = 3'd2,
    REG_HALF_WIDTH  = 3'd3,
    REG_HALF_HEIGHT = 3'd4
  } cfg_reg_t;

  // Saturated 32-bit value with overflow flag
  typedef struct packed {
    logic              ovf;
    logic signed [31:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [47:0] v);
    sat_t s;
    s.ovf = 1'b0;
    s.val = v[31:0];
    if (v > S32_MAX) begin
      s.ovf = 1'b1;
      s.val = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN) begin
      s.ovf = 1'b1;
      s.val = 32'sh8000_0000;
    end
    return s;
  endfunction

endpackage

[hdl/bobs_alu.sv]
// Shared iterative unit: shift-add multiply, restoring divide, digit square root.
module bobs_alu (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bobs_pkg::alu_req_t           req,
  input  logic [bobs_pkg::ALU_W-1:0]   opa,
  input  logic [bobs_pkg::ALU_W-1:0]   opb,
  output bobs_pkg::alu_rsp_t           rsp,
  output logic [bobs_pkg::ALU_W-1:0]   res
);

  localparam int W     = bobs_pkg::ALU_W;
  localparam int CNT_W = $clog2(bobs_pkg::DIV_STEPS);
  localparam int SQ_MSB = bobs_pkg::SQRT_IN_MSB;

  logic                run_r;
  logic                done_r;
  bobs_pkg::alu_op_t   op_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [W-1:0]        acc_r;
  logic [W-1:0]        a_r;
  logic [W-1:0]        b_r;

  logic [W-1:0]        ad_a;
  logic [W-1:0]        ad_b;
  logic                ad_sub;
  logic [W:0]          sum;
  logic                no_borrow;

  // One adder/subtractor serves all three operations
  always_comb begin
    case (op_r)
      bobs_pkg::ALU_MUL: begin
        ad_a   = acc_r;
        ad_b   = a_r;
        ad_sub = 1'b0;
      end
      bobs_pkg::ALU_DIV: begin
        ad_a   = {acc_r[W-2:0], b_r[W-1]};
        ad_b   = a_r;
        ad_sub = 1'b1;
      end
      bobs_pkg::ALU_SQRT: begin
        ad_a   = {acc_r[W-3:0], b_r[SQ_MSB -: 2]};
        ad_b   = {a_r[W-3:0], 2'b01};
        ad_sub = 1'b1;
      end
      default: begin
        ad_a   = acc_r;
        ad_b   = '0;
        ad_sub = 1'b0;
      end
    endcase
    sum       = {1'b0, ad_a} + {1'b0, (ad_sub ? ~ad_b : ad_b)} + (W+1)'(ad_sub);
    no_borrow = sum[W];
  end

  // Control: run flag, op, iteration count, done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      op_r   <= bobs_pkg::ALU_MUL;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        op_r  <= req.op;
        cnt_r <= (req.op == bobs_pkg::ALU_SQRT) ? CNT_W'(bobs_pkg::SQRT_STEPS - 1)
                                                : CNT_W'(bobs_pkg::DIV_STEPS - 1);
      end else if (run_r) begin
        if (op_r == bobs_pkg::ALU_MUL) begin
          if (b_r == '0) begin
            run_r  <= 1'b0;
            done_r <= 1'b1;
          end
        end else if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Datapath: one step per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= opa;
      b_r   <= opb;
      acc_r <= '0;
    end else if (run_r) begin
      case (op_r)
        bobs_pkg::ALU_MUL: begin
          if (b_r != '0) begin
            if (b_r[0]) acc_r <= sum[W-1:0];
            a_r <= a_r << 1;
            b_r <= b_r >> 1;
          end
        end
        bobs_pkg::ALU_DIV: begin
          acc_r <= no_borrow ? sum[W-1:0] : ad_a;
          b_r   <= {b_r[W-2:0], no_borrow};
        end
        bobs_pkg::ALU_SQRT: begin
          acc_r <= no_borrow ? sum[W-1:0] : ad_a;
          a_r   <= {a_r[W-2:0], no_borrow};
          b_r   <= b_r << 2;
        end
        default: begin
          acc_r <= acc_r;
        end
      endcase
    end
  end

  assign rsp.done = done_r;

  // Product in acc, quotient in b, root in a
  always_comb begin
    case (op_r)
      bobs_pkg::ALU_MUL:  res = acc_r;
      bobs_pkg::ALU_DIV:  res = b_r;
      bobs_pkg::ALU_SQRT: res = a_r;
      default:            res = acc_r;
    endcase
  end

endmodule

[hdl/ballistic_and_orbital_body_step.sv]
// Top level: body state, configuration registers and step sequencer.
//
// Channel | Ports                          | Content
// in      | in_tvalid/in_tready/in_tdata   | one action item
// out     | out_tvalid/out_tready/out_tdata| state after the item, fault in out_tuser
// cfg     | cfg_valid/cfg_ready/cfg_index  | register write, data on cfg_data
//
// A ballistic step runs 7 multiplies, 1 square root and 2 divides on the shared unit, then
// four reciprocal multiplies for the /10 and /200 updates. An orbital step runs 5 multiplies,
// 1 square root, 2 divides and the same four updates, but goes straight to the updates when
// the attractor sits on the body. Load and unused actions go from idle straight to output.
// The multiplier operand's bit length sets the multiply time; the restoring divides dominate.
// Reset (rst_n low, synchronous) clears the state to zero and the registers to defaults.
// in_tready is high only while idle; a stalled result holds the sequencer in its last state.
module ballistic_and_orbital_body_step #(
  parameter int FRAC_BITS = bobs_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // action[1:0], attractor_x[33:2], attractor_y[65:34], attractor_mass[96:66],
  // load_x[128:97], load_y[160:129], load_vx[192:161], load_vy[224:193], zero pad
  input  logic [231:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x[31:0], pos_y[63:32], vel_x[95:64], vel_y[127:96], screen_y[159:128]
  output logic [159:0] out_tdata,
  // fault[0]
  output logic         out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int W = bobs_pkg::ALU_W;
  localparam logic signed [47:0] SCREEN_BASE = 48'sd720 <<< FRAC_BITS;

  // Reciprocals for exact floor division of dividends below 2^45: q = (n * R) >> FIN_SH
  localparam int FIN_SH = 53;
  localparam logic [63:0] RCP_10  = 64'(((128'd1 << FIN_SH) + 128'd9) / 128'd10);
  localparam logic [63:0] RCP_200 = 64'(((128'd1 << FIN_SH) + 128'd199) / 128'd200);

  typedef enum logic [23:0] {
    ST_IDLE   = 24'h000001,
    ST_B_MXX  = 24'h000002,
    ST_B_MYY  = 24'h000004,
    ST_B_SQRT = 24'h000008,
    ST_B_KV   = 24'h000010,
    ST_B_PX   = 24'h000020,
    ST_B_NX   = 24'h000040,
    ST_B_DX   = 24'h000080,
    ST_B_PY   = 24'h000100,
    ST_B_NY   = 24'h000200,
    ST_B_DY   = 24'h000400,
    ST_O_DXX  = 24'h000800,
    ST_O_DYY  = 24'h001000,
    ST_O_SQRT = 24'h002000,
    ST_O_DEN  = 24'h004000,
    ST_O_NX   = 24'h008000,
    ST_O_DX   = 24'h010000,
    ST_O_NY   = 24'h020000,
    ST_O_DY   = 24'h040000,
    ST_F_PX   = 24'h080000,
    ST_F_PY   = 24'h100000,
    ST_F_VX   = 24'h200000,
    ST_F_VY   = 24'h400000,
    ST_OUT    = 24'h800000
  } state_t;

  state_t state_r, state_nxt;
  logic   issued_r, issued_nxt;

  // Configuration registers
  logic [30:0]        drag_r;
  logic signed [31:0] grav_r;
  logic [30:0]        mass_r;
  logic [9:0]         hw_r;
  logic [9:0]         hh_r;

  // Body state
  logic signed [31:0] x_r, y_r, vx_r, vy_r;

  // Per-item working registers
  logic               orb_r;
  logic               fault_r;
  logic [32:0]        mx_r, my_r;
  logic               neg_x_r, neg_y_r;
  logic [30:0]        am_r;
  logic [W-1:0]       tmp_r;
  logic [W-1:0]       sum_r;
  logic [W-1:0]       den_r;
  logic [63:0]        prod_r;
  logic [33:0]        root_r;
  logic signed [43:0] acx_r, acy_r;

  // Output register
  logic               out_tvalid_r;
  logic [159:0]       out_tdata_r;
  logic               out_tuser_r;

  // Shared unit
  bobs_pkg::alu_req_t alu_req;
  bobs_pkg::alu_rsp_t alu_rsp;
  logic [W-1:0]       alu_opa, alu_opb, alu_res;

  bobs_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .opa   (alu_opa),
    .opb   (alu_opb),
    .rsp   (alu_rsp),
    .res   (alu_res)
  );

  // Input field views
  bobs_pkg::action_t  in_act;
  logic signed [31:0] in_att_x, in_att_y, in_ld_x, in_ld_y, in_ld_vx, in_ld_vy;
  logic [30:0]        in_att_m;
  assign in_act   = bobs_pkg::action_t'(in_tdata[1:0]);
  assign in_att_x = in_tdata[33:2];
  assign in_att_y = in_tdata[65:34];
  assign in_att_m = in_tdata[96:66];
  assign in_ld_x  = in_tdata[128:97];
  assign in_ld_y  = in_tdata[160:129];
  assign in_ld_vx = in_tdata[192:161];
  assign in_ld_vy = in_tdata[224:193];

  logic in_acc;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign cfg_ready = 1'b1;

  // Setup values computed at accept
  logic signed [33:0] dx_o, dy_o, vx_w, vy_w;
  logic [30:0]        mass_eff;
  assign dx_o     = 34'(in_att_x) - 34'(x_r);
  assign dy_o     = 34'(in_att_y) - 34'(y_r);
  assign vx_w     = 34'(vx_r);
  assign vy_w     = 34'(vy_r);
  assign mass_eff = (mass_r == '0) ? 31'd1 : mass_r;

  // Small constant-size products
  logic [19:0] hw2, hh2;
  logic [37:0] am100;
  assign hw2   = 20'(hw_r) * 20'(hw_r);
  assign hh2   = 20'(hh_r) * 20'(hh_r);
  assign am100 = 38'(am_r) * 38'd100;

  // Acceleration clamp on the unit's quotient
  logic               acc_ovf;
  logic [40:0]        acc_mag;
  logic signed [43:0] acc_pos, acc_val;
  logic               acc_neg;
  always_comb begin
    acc_ovf = (|alu_res[W-1:41]) | (alu_res[40] & (|alu_res[39:0]));
    acc_mag = acc_ovf ? (41'd1 << 40) : alu_res[40:0];
    acc_pos = $signed({3'b000, acc_mag});
    acc_neg = (state_r == ST_B_DX || state_r == ST_O_DX) ? neg_x_r : neg_y_r;
    acc_val = acc_neg ? -acc_pos : acc_pos;
  end

  // Final update dividends and results
  logic signed [44:0] vx20, vy20, dpx, dpy, fin_n, fin_q;
  logic [44:0]        fin_mag;
  logic [63:0]        fin_rcp;
  logic signed [31:0] fin_old;
  bobs_pkg::sat_t     fin_sat, scr_sat;
  assign vx20 = (45'(vx_r) <<< 4) + (45'(vx_r) <<< 2);
  assign vy20 = (45'(vy_r) <<< 4) + (45'(vy_r) <<< 2);
  assign dpx  = orb_r ? 45'(vx_r) : vx20 + 45'(acx_r);
  assign dpy  = orb_r ? 45'(vy_r) : vy20 + 45'(acy_r);

  always_comb begin
    case (state_r)
      ST_F_PX: begin
        fin_n   = dpx;
        fin_rcp = orb_r ? RCP_10 : RCP_200;
        fin_old = x_r;
      end
      ST_F_PY: begin
        fin_n   = dpy;
        fin_rcp = orb_r ? RCP_10 : RCP_200;
        fin_old = y_r;
      end
      ST_F_VX: begin
        fin_n   = 45'(acx_r);
        fin_rcp = RCP_10;
        fin_old = vx_r;
      end
      ST_F_VY: begin
        fin_n   = 45'(acy_r);
        fin_rcp = RCP_10;
        fin_old = vy_r;
      end
      default: begin
        fin_n   = '0;
        fin_rcp = RCP_10;
        fin_old = '0;
      end
    endcase
    fin_mag = fin_n[44] ? 45'(-fin_n) : 45'(fin_n);
    // Quotient magnitude sits above the reciprocal's fraction bits; truncates toward zero
    fin_q   = fin_n[44] ? -$signed(alu_res[FIN_SH +: 45]) : $signed(alu_res[FIN_SH +: 45]);
    fin_sat = bobs_pkg::sat32(48'(fin_old) + 48'(fin_q));
    scr_sat = bobs_pkg::sat32(SCREEN_BASE - 48'(y_r));
  end

  // Operand selection for the shared unit
  always_comb begin
    alu_req.start = (state_r != ST_IDLE) && (state_r != ST_OUT) && !issued_r;
    alu_req.op    = bobs_pkg::ALU_MUL;
    alu_opa       = '0;
    alu_opb       = '0;
    case (state_r)
      ST_B_MXX, ST_O_DXX: begin
        alu_opa = W'(mx_r);
        alu_opb = W'(mx_r);
      end
      ST_B_MYY, ST_O_DYY: begin
        alu_opa = W'(my_r);
        alu_opb = W'(my_r);
      end
      ST_B_SQRT, ST_O_SQRT: begin
        alu_req.op = bobs_pkg::ALU_SQRT;
        alu_opb    = sum_r;
      end
      ST_B_KV: begin
        alu_opa = W'(drag_r);
        alu_opb = W'(root_r);
      end
      ST_B_PX: begin
        alu_opa = W'(mx_r);
        alu_opb = W'(hw2);
      end
      ST_B_PY: begin
        alu_opa = W'(my_r);
        alu_opb = W'(hh2);
      end
      ST_B_NX, ST_B_NY: begin
        alu_opa = tmp_r;
        alu_opb = W'(prod_r);
      end
      ST_O_DEN: begin
        alu_opa = sum_r;
        alu_opb = W'(root_r);
      end
      ST_O_NX: begin
        alu_opa = W'(am100) << (2 * FRAC_BITS);
        alu_opb = W'(mx_r);
      end
      ST_O_NY: begin
        alu_opa = W'(am100) << (2 * FRAC_BITS);
        alu_opb = W'(my_r);
      end
      ST_B_DX, ST_B_DY, ST_O_DX, ST_O_DY: begin
        alu_req.op = bobs_pkg::ALU_DIV;
        alu_opa    = den_r;
        alu_opb    = sum_r;
      end
      ST_F_PX, ST_F_PY, ST_F_VX, ST_F_VY: begin
        alu_req.op = bobs_pkg::ALU_MUL;
        alu_opa    = W'(fin_rcp);
        alu_opb    = W'(fin_mag);
      end
      default: begin
        alu_req.op = bobs_pkg::ALU_MUL;
      end
    endcase
  end

  // Sequencer next state
  logic alu_state, alu_done;
  logic [W-1:0] sq_sum;
  assign alu_state     = (state_r != ST_IDLE) && (state_r != ST_OUT);
  assign alu_done      = alu_rsp.done;
  assign sq_sum        = tmp_r + alu_res;

  always_comb begin
    state_nxt  = state_r;
    issued_nxt = issued_r;
    if (alu_req.start) issued_nxt = 1'b1;
    if (alu_state && alu_done) issued_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_act)
            bobs_pkg::ACT_BALLISTIC: state_nxt = ST_B_MXX;
            bobs_pkg::ACT_ORBITAL:   state_nxt = ST_O_DXX;
            default:                 state_nxt = ST_OUT;
          endcase
        end
      end
      ST_B_MXX:  if (alu_done) state_nxt = ST_B_MYY;
      ST_B_MYY:  if (alu_done) state_nxt = ST_B_SQRT;
      ST_B_SQRT: if (alu_done) state_nxt = ST_B_KV;
      ST_B_KV:   if (alu_done) state_nxt = ST_B_PX;
      ST_B_PX:   if (alu_done) state_nxt = ST_B_NX;
      ST_B_NX:   if (alu_done) state_nxt = ST_B_DX;
      ST_B_DX:   if (alu_done) state_nxt = ST_B_PY;
      ST_B_PY:   if (alu_done) state_nxt = ST_B_NY;
      ST_B_NY:   if (alu_done) state_nxt = ST_B_DY;
      ST_B_DY:   if (alu_done) state_nxt = ST_F_PX;
      ST_O_DXX:  if (alu_done) state_nxt = ST_O_DYY;
      ST_O_DYY:  if (alu_done) state_nxt = (sq_sum == '0) ? ST_F_VX : ST_O_SQRT;
      ST_O_SQRT: if (alu_done) state_nxt = ST_O_DEN;
      ST_O_DEN:  if (alu_done) state_nxt = ST_O_NX;
      ST_O_NX:   if (alu_done) state_nxt = ST_O_DX;
      ST_O_DX:   if (alu_done) state_nxt = ST_O_NY;
      ST_O_NY:   if (alu_done) state_nxt = ST_O_DY;
      ST_O_DY:   if (alu_done) state_nxt = ST_F_VX;
      // Ballistic moves position first, orbital moves velocity first
      ST_F_PX:   if (alu_done) state_nxt = ST_F_PY;
      ST_F_PY:   if (alu_done) state_nxt = orb_r ? ST_OUT : ST_F_VX;
      ST_F_VX:   if (alu_done) state_nxt = ST_F_VY;
      ST_F_VY:   if (alu_done) state_nxt = orb_r ? ST_F_PX : ST_OUT;
      ST_OUT:    if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control, configuration and body state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      issued_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
      drag_r       <= '0;
      grav_r       <= '0;
      mass_r       <= 31'd65536;
      hw_r         <= '0;
      hh_r         <= '0;
      x_r          <= '0;
      y_r          <= '0;
      vx_r         <= '0;
      vy_r         <= '0;
      fault_r      <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;

      // Register writes
      if (cfg_valid) begin
        case (cfg_index)
          bobs_pkg::REG_DRAG_COEFF:  drag_r <= cfg_data[30:0];
          bobs_pkg::REG_GRAVITY:     grav_r <= cfg_data;
          bobs_pkg::REG_BODY_MASS:   mass_r <= cfg_data[30:0];
          bobs_pkg::REG_HALF_WIDTH:  hw_r   <= cfg_data[9:0];
          bobs_pkg::REG_HALF_HEIGHT: hh_r   <= cfg_data[9:0];
          default: ;
        endcase
      end

      // Output handshake
      if (state_r == ST_OUT && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      if (in_acc) begin
        fault_r <= 1'b0;
        if (in_act == bobs_pkg::ACT_LOAD) begin
          x_r  <= in_ld_x;
          y_r  <= in_ld_y;
          vx_r <= in_ld_vx;
          vy_r <= in_ld_vy;
        end
      end

      // State updates and fault sources during the step
      if (alu_done) begin
        case (state_r)
          ST_B_DX, ST_B_DY, ST_O_DX, ST_O_DY: if (acc_ovf) fault_r <= 1'b1;
          ST_O_DYY: if (sq_sum == '0) fault_r <= 1'b1;
          ST_F_PX: begin
            x_r <= fin_sat.val;
            if (fin_sat.ovf) fault_r <= 1'b1;
          end
          ST_F_PY: begin
            y_r <= fin_sat.val;
            if (fin_sat.ovf) fault_r <= 1'b1;
          end
          ST_F_VX: begin
            vx_r <= fin_sat.val;
            if (fin_sat.ovf) fault_r <= 1'b1;
          end
          ST_F_VY: begin
            vy_r <= fin_sat.val;
            if (fin_sat.ovf) fault_r <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Working registers and output payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      orb_r <= (in_act == bobs_pkg::ACT_ORBITAL);
      am_r  <= in_att_m;
      den_r <= W'(mass_eff) << FRAC_BITS;
      if (in_act == bobs_pkg::ACT_ORBITAL) begin
        mx_r    <= 33'(dx_o[33] ? -dx_o : dx_o);
        my_r    <= 33'(dy_o[33] ? -dy_o : dy_o);
        neg_x_r <= dx_o[33];
        neg_y_r <= dy_o[33];
      end else begin
        mx_r    <= 33'(vx_w[33] ? -vx_w : vx_w);
        my_r    <= 33'(vy_w[33] ? -vy_w : vy_w);
        neg_x_r <= !vx_r[31] && (vx_r != '0);
        neg_y_r <= !vy_r[31] && (vy_r != '0);
      end
    end

    if (alu_done) begin
      case (state_r)
        ST_B_MXX, ST_O_DXX: tmp_r  <= alu_res;
        ST_B_MYY, ST_O_DYY: sum_r  <= sq_sum;
        ST_B_SQRT, ST_O_SQRT: root_r <= alu_res[33:0];
        ST_B_KV:            tmp_r  <= alu_res;
        ST_B_PX, ST_B_PY:   prod_r <= alu_res[63:0];
        ST_B_NX, ST_B_NY, ST_O_NX, ST_O_NY: sum_r <= alu_res;
        ST_O_DEN:           den_r  <= alu_res;
        ST_B_DX, ST_O_DX:   acx_r  <= acc_val;
        ST_B_DY:            acy_r  <= acc_val - 44'(grav_r);
        ST_O_DY:            acy_r  <= acc_val;
        default: ;
      endcase
      // Zero distance: no pull
      if (state_r == ST_O_DYY && sq_sum == '0) begin
        acx_r <= '0;
        acy_r <= '0;
      end
    end

    if (state_r == ST_OUT && (!out_tvalid_r || out_tready)) begin
      out_tdata_r <= {scr_sat.val, vy_r, vx_r, y_r, x_r};
      out_tuser_r <= fault_r | scr_sat.ovf;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

[hdl/bobs_chk.sv]
// Port-level checker for the body step block, bound to the top level.
module bobs_chk #(
  parameter int FRAC_BITS = bobs_pkg::FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [159:0] out_tdata,
  input logic         out_tuser
);

  localparam logic [31:0] SCREEN_BASE = 32'(48'sd720 <<< FRAC_BITS);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // The block is busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  // A new result only appears after the block was busy
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result raised without work");

  // Without a fault the screen row is 720 minus y
  a_screen_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[159:128] == SCREEN_BASE - out_tdata[63:32])
    else $error("screen row mismatch");

endmodule

bind ballistic_and_orbital_body_step bobs_chk #(.FRAC_BITS(FRAC_BITS)) u_bobs_chk (.*);

[tb/sv/testbench.sv]
// Self-checking testbench for the ballistic/orbital body step block.
`timescale 1ns / 1ps

module testbench;

  localparam int FB          = bobs_pkg::FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int TAIL_CYCLES = 50;
  localparam int HOLD_CYCLES = 6000;

  typedef struct {
    bobs_pkg::action_t  act;
    logic signed [31:0] att_x;
    logic signed [31:0] att_y;
    logic [30:0]        att_m;
    logic signed [31:0] ld_x;
    logic signed [31:0] ld_y;
    logic signed [31:0] ld_vx;
    logic signed [31:0] ld_vy;
  } body_item_t;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] scr_y;
    bit                 fault;
  } body_state_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [231:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [159:0] out_tdata;
  logic         out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;

  ballistic_and_orbital_body_step dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the body state and registers
  logic signed [31:0] body_x, body_y, body_vx, body_vy;
  logic [30:0]        drag_k;
  logic signed [31:0] grav;
  logic [30:0]        mass;
  logic [9:0]         half_w, half_h;

  body_state_t expected_states[$];
  int          error_count;
  int          items_sent;
  int          results_seen;
  int          n_ballistic, n_orbital, n_load, n_idle_act;
  longint      cycle_count;
  bit          no_idle;
  int          out_wait;
  int          out_hold;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Arithmetic helpers of the predictor
  function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= n) r = t;
    end
    return r[63:0];
  endfunction

  function automatic logic signed [63:0] clamp_accel(input logic [127:0] m, input bit neg,
                                                      inout bit f);
    logic [63:0] v;
    v = m[63:0];
    if (m > (128'd1 << 40)) begin
      v = 64'd1 << 40;
      f = 1'b1;
    end
    return neg ? -$signed(v) : $signed(v);
  endfunction

  function automatic logic signed [31:0] sat_word(input logic signed [63:0] v, inout bit f);
    if (v > 64'sd2147483647) begin
      f = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      f = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Next body state for one accepted item; updates the shadow state
  function automatic body_state_t next_body_state(input body_item_t it);
    body_state_t        r;
    bit                 f;
    logic signed [63:0] x, y, vx, vy, ax, ay, dx, dy, nvx, nvy;
    logic [63:0]        mx, my, spd, kv, m, lin_x, lin_y;
    logic [127:0]       den, r2, num, mdx, mdy;
    f  = 1'b0;
    x  = body_x;
    y  = body_y;
    vx = body_vx;
    vy = body_vy;
    case (it.act)
      bobs_pkg::ACT_BALLISTIC: begin
        mx    = vx < 0 ? -vx : vx;
        my    = vy < 0 ? -vy : vy;
        spd   = floor_sqrt({64'd0, mx * mx + my * my});
        kv    = {33'd0, drag_k} * spd;
        m     = (mass == 0) ? 64'd1 : {33'd0, mass};
        den   = {64'd0, m} << FB;
        lin_x = mx * {54'd0, half_w} * {54'd0, half_w};
        lin_y = my * {54'd0, half_h} * {54'd0, half_h};
        ax = clamp_accel(({64'd0, kv} * {64'd0, lin_x}) / den, vx > 0, f);
        ay = clamp_accel(({64'd0, kv} * {64'd0, lin_y}) / den, vy > 0, f) - grav;
        body_x  = sat_word(x + (20 * vx + ax) / 200, f);
        body_y  = sat_word(y + (20 * vy + ay) / 200, f);
        body_vx = sat_word(vx + ax / 10, f);
        body_vy = sat_word(vy + ay / 10, f);
      end
      bobs_pkg::ACT_ORBITAL: begin
        dx  = 64'(it.att_x) - x;
        dy  = 64'(it.att_y) - y;
        mdx = {64'd0, (dx < 0 ? -dx : dx)};
        mdy = {64'd0, (dy < 0 ? -dy : dy)};
        r2  = mdx * mdx + mdy * mdy;
        ax  = 0;
        ay  = 0;
        // attractor on top of the body: no pull, fault
        if (r2 == 0) begin
          f = 1'b1;
        end else begin
          num = ({97'd0, it.att_m} * 128'd100) << (2 * FB);
          den = r2 * {64'd0, floor_sqrt(r2)};
          ax  = clamp_accel((num * mdx) / den, dx < 0, f);
          ay  = clamp_accel((num * mdy) / den, dy < 0, f);
        end
        // semi-implicit: position moves with the new velocity
        body_vx = sat_word(vx + ax / 10, f);
        body_vy = sat_word(vy + ay / 10, f);
        nvx     = body_vx;
        nvy     = body_vy;
        body_x  = sat_word(x + nvx / 10, f);
        body_y  = sat_word(y + nvy / 10, f);
      end
      bobs_pkg::ACT_LOAD: begin
        body_x  = it.ld_x;
        body_y  = it.ld_y;
        body_vx = it.ld_vx;
        body_vy = it.ld_vy;
      end
      default: ;
    endcase
    r.pos_x = body_x;
    r.pos_y = body_y;
    r.vel_x = body_vx;
    r.vel_y = body_vy;
    r.scr_y = sat_word((64'sd720 <<< FB) - 64'(body_y), f);
    r.fault = f;
    return r;
  endfunction

  // Send one item; entered and left at a falling edge
  task automatic send_item(input body_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {7'd0, it.ld_vy, it.ld_vx, it.ld_y, it.ld_x, it.att_m, it.att_y, it.att_x,
                 it.act};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_states.push_back(next_body_state(it));
    items_sent++;
    case (it.act)
      bobs_pkg::ACT_BALLISTIC: n_ballistic++;
      bobs_pkg::ACT_ORBITAL:   n_orbital++;
      bobs_pkg::ACT_LOAD:      n_load++;
      default:                 n_idle_act++;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (expected_states.size() != 0) @(negedge clk);
  endtask

  // Register write, only with nothing in flight
  task automatic write_reg(input bobs_pkg::cfg_reg_t idx, input logic [31:0] val);
    wait_drained();
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bobs_pkg::REG_DRAG_COEFF:  drag_k = val[30:0];
      bobs_pkg::REG_GRAVITY:     grav   = val;
      bobs_pkg::REG_BODY_MASS:   mass   = val[30:0];
      bobs_pkg::REG_HALF_WIDTH:  half_w = val[9:0];
      bobs_pkg::REG_HALF_HEIGHT: half_h = val[9:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all(input logic [31:0] k, input logic [31:0] g, input logic [31:0] m,
                           input logic [31:0] hw, input logic [31:0] hh);
    write_reg(bobs_pkg::REG_DRAG_COEFF, k);
    write_reg(bobs_pkg::REG_GRAVITY, g);
    write_reg(bobs_pkg::REG_BODY_MASS, m);
    write_reg(bobs_pkg::REG_HALF_WIDTH, hw);
    write_reg(bobs_pkg::REG_HALF_HEIGHT, hh);
  endtask

  function automatic body_item_t mk_item(input bobs_pkg::action_t a);
    body_item_t it;
    it.act   = a;
    it.att_x = '0;
    it.att_y = '0;
    it.att_m = '0;
    it.ld_x  = '0;
    it.ld_y  = '0;
    it.ld_vx = '0;
    it.ld_vy = '0;
    return it;
  endfunction

  function automatic body_item_t mk_load(input logic [31:0] x, input logic [31:0] y,
                                         input logic [31:0] vx, input logic [31:0] vy);
    body_item_t it;
    it       = mk_item(bobs_pkg::ACT_LOAD);
    it.ld_x  = x;
    it.ld_y  = y;
    it.ld_vx = vx;
    it.ld_vy = vy;
    return it;
  endfunction

  function automatic body_item_t mk_orbit(input logic [31:0] x, input logic [31:0] y,
                                          input logic [30:0] m);
    body_item_t it;
    it       = mk_item(bobs_pkg::ACT_ORBITAL);
    it.att_x = x;
    it.att_y = y;
    it.att_m = m;
    return it;
  endfunction

  // Q16.16 value: half physical magnitudes, a third full range, the rest corners
  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return 32'($signed($urandom_range(0, 2000 << FB)) - (1000 << FB));
      3: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      4: return 32'($signed($urandom_range(0, 200 << FB)) - (100 << FB));
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          default: return 32'd0;
        endcase
      end
    endcase
  endfunction

  function automatic body_item_t rand_item();
    body_item_t it;
    int         pick;
    it    = mk_item(bobs_pkg::ACT_BALLISTIC);
    pick  = $urandom_range(0, 99);
    // random content in every field, whatever the action
    it.att_x = rand_q();
    it.att_y = rand_q();
    it.att_m = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 50 << FB));
    it.ld_x  = rand_q();
    it.ld_y  = rand_q();
    it.ld_vx = rand_q();
    it.ld_vy = rand_q();
    if (pick < 15)      it.act = bobs_pkg::ACT_LOAD;
    else if (pick < 55) it.act = bobs_pkg::ACT_BALLISTIC;
    else if (pick < 96) it.act = bobs_pkg::ACT_ORBITAL;
    else                it.act = bobs_pkg::ACT_NONE;
    return it;
  endfunction

  // Receiver stalls: a random wait per result, or a long hold counted here
  initial begin
    out_tready = 1'b0;
    out_wait   = 0;
    out_hold   = 0;
    forever begin
      @(negedge clk);
      if (out_hold > 0) begin
        out_tready = 1'b0;
        out_hold--;
      end else if (out_wait > 0 && !no_idle) begin
        out_tready = 1'b0;
        out_wait--;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    body_state_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      out_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
      if (expected_states.size() == 0) begin
        $error("result transaction with nothing expected");
        error_count++;
      end else begin
        e = expected_states.pop_front();
        check_field("pos_x", e.pos_x, out_tdata[31:0]);
        check_field("pos_y", e.pos_y, out_tdata[63:32]);
        check_field("vel_x", e.vel_x, out_tdata[95:64]);
        check_field("vel_y", e.vel_y, out_tdata[127:96]);
        check_field("screen_y", e.scr_y, out_tdata[159:128]);
        check_field("fault", 32'(e.fault), 32'(out_tuser));
      end
    end
  end

  // State after reset, registers at their defaults
  task automatic test_reset_state();
    send_item(mk_item(bobs_pkg::ACT_NONE));
    send_item(mk_item(bobs_pkg::ACT_BALLISTIC));
    send_item(mk_orbit(32'd0, 32'd0, 31'd65536));
  endtask

  // Field extremes, every action and the named special cases
  task automatic test_directed();
    send_item(mk_load(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_item(mk_item(bobs_pkg::ACT_BALLISTIC));
    send_item(mk_load(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_item(mk_item(bobs_pkg::ACT_NONE));
    send_item(mk_orbit(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
    write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd1023, 32'd1023);
    send_item(mk_load(32'd100 << FB, 32'd100 << FB, 32'd5 << FB, 32'hFFFD_0000));
    send_item(mk_item(bobs_pkg::ACT_BALLISTIC));
    send_item(mk_item(bobs_pkg::ACT_BALLISTIC));
    write_all(32'd1 << 12, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0);
    send_item(mk_load(32'd0, 32'd0, 32'd1 << FB, 32'd2 << FB));
    send_item(mk_item(bobs_pkg::ACT_BALLISTIC));
    write_all(32'd1 << 10, 32'd10 << FB, 32'd1 << FB, 32'd2, 32'd3);
    send_item(mk_load(32'd0, 32'd50 << FB, 32'd20 << FB, 32'd30 << FB));
    send_item(mk_item(bobs_pkg::ACT_BALLISTIC));
    send_item(mk_item(bobs_pkg::ACT_BALLISTIC));
    // attractor on the body
    send_item(mk_load(32'd7 << FB, 32'hFFFB_0000, 32'd1 << FB, 32'd0));
    send_item(mk_orbit(32'd7 << FB, 32'hFFFB_0000, 31'd1 << FB));
    send_item(mk_orbit(32'd10 << FB, 32'd0, 31'd10 << FB));
    send_item(mk_orbit(32'd7 << FB, 32'hFFFB_0001, 31'h7FFF_FFFF));
    send_item(mk_orbit(32'h8000_0000, 32'h8000_0000, 31'd0));
    send_item(mk_load(32'd0, 32'd720 << FB, 32'd0, 32'd0));
    send_item(mk_item(bobs_pkg::ACT_NONE));
  endtask

  // Random stream under the current register setting
  task automatic test_random_phase(input int n);
    repeat (n) send_item(rand_item());
  endtask

  // Receiver holds off long while the sender keeps offering items
  task automatic test_output_backpressure();
    wait_drained();
    out_hold = HOLD_CYCLES;
    repeat (6) send_item(rand_item());
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = bobs_pkg::REG_DRAG_COEFF;
    cfg_data     = '0;
    error_count  = 0;
    items_sent   = 0;
    results_seen = 0;
    n_ballistic  = 0;
    n_orbital    = 0;
    n_load       = 0;
    n_idle_act   = 0;
    no_idle      = 1'b0;
    body_x  = '0;
    body_y  = '0;
    body_vx = '0;
    body_vy = '0;
    drag_k  = '0;
    grav    = '0;
    mass    = 31'd65536;
    half_w  = '0;
    half_h  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_state();
    test_directed();

    write_all(32'd0, 32'd0, 32'd1 << FB, 32'd0, 32'd0);
    test_random_phase(300);
    write_all(32'd1 << 8, 32'd98 << 12, 32'd2 << FB, 32'd4, 32'd4);
    test_random_phase(300);
    test_output_backpressure();
    write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd1023, 32'd1023);
    no_idle = 1'b1;
    test_random_phase(200);
    no_idle = 1'b0;
    repeat (4) begin
      write_all($urandom_range(0, 1 << 14), $urandom, $urandom_range(0, 1 << 22),
                $urandom_range(0, 1023), $urandom_range(0, 1023));
      test_random_phase(280);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d items: %0d ballistic, %0d orbital, %0d load, %0d unused action,",
             items_sent, n_ballistic, n_orbital, n_load, n_idle_act);
    $display("%0d results checked across several register settings and a long output hold.",
             results_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
hdl/bobs_pkg.sv
hdl/bobs_alu.sv
hdl/ballistic_and_orbital_body_step.sv
hdl/bobs_chk.sv
tb/sv/testbench.sv
